@@ sv/b32dec_pkg.sv @@
`timescale 1ns / 1ps

package b32dec_pkg;

    localparam int unsigned CharW     = 8;
    localparam int unsigned SymW      = 5;
    localparam int unsigned ByteW     = 8;
    localparam int unsigned CountW    = 3;
    localparam int unsigned PendW     = 7;
    localparam int unsigned QueueDepth = 4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MIXED     = 2'd1,
        ST_INVALID   = 2'd2,
        ST_NONZERO_PAD = 2'd3
    } status_t;

    typedef struct packed {
        logic            sym_valid;
        logic [SymW-1:0] sym;
        logic            upper;
        logic            lower;
        logic            last;
    } class_t;

    typedef struct packed {
        logic            valid;
        logic [SymW-1:0] sym;
    } sym_t;

    function automatic sym_t sym_lookup(input logic [CharW-1:0] ch);
        logic [CharW-1:0] lc;
        sym_t             r;
        lc = ch;
        if (ch >= 8'h41 && ch <= 8'h5a) begin
            lc = ch | 8'h20;
        end
        r.valid = 1'b1;
        unique case (lc)
            8'h71:   r.sym = 5'd0;
            8'h70:   r.sym = 5'd1;
            8'h7a:   r.sym = 5'd2;
            8'h72:   r.sym = 5'd3;
            8'h79:   r.sym = 5'd4;
            8'h39:   r.sym = 5'd5;
            8'h78:   r.sym = 5'd6;
            8'h38:   r.sym = 5'd7;
            8'h67:   r.sym = 5'd8;
            8'h66:   r.sym = 5'd9;
            8'h32:   r.sym = 5'd10;
            8'h74:   r.sym = 5'd11;
            8'h76:   r.sym = 5'd12;
            8'h64:   r.sym = 5'd13;
            8'h77:   r.sym = 5'd14;
            8'h30:   r.sym = 5'd15;
            8'h73:   r.sym = 5'd16;
            8'h33:   r.sym = 5'd17;
            8'h6a:   r.sym = 5'd18;
            8'h6e:   r.sym = 5'd19;
            8'h35:   r.sym = 5'd20;
            8'h34:   r.sym = 5'd21;
            8'h6b:   r.sym = 5'd22;
            8'h68:   r.sym = 5'd23;
            8'h63:   r.sym = 5'd24;
            8'h65:   r.sym = 5'd25;
            8'h36:   r.sym = 5'd26;
            8'h6d:   r.sym = 5'd27;
            8'h75:   r.sym = 5'd28;
            8'h61:   r.sym = 5'd29;
            8'h37:   r.sym = 5'd30;
            8'h6c:   r.sym = 5'd31;
            default: begin
                r.valid = 1'b0;
                r.sym   = '0;
            end
        endcase
        return r;
    endfunction

endpackage

@@ sv/base32_symbol_to_byte_decoder.sv @@
`timescale 1ns / 1ps
// A character is queued, then decoded from the queue head into the registered output.
// Throughput: one character per cycle while the output is not stalled; a final
// character that completes a byte yields a byte and then the status word.
// The input queue absorbs short output stalls before the input is held off.
// Reset is synchronous and active low; it empties the queue and clears the accumulator, flags and valids.

module base32_symbol_to_byte_decoder #(
    parameter int unsigned QueueDepth = b32dec_pkg::QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // character[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // data_byte[7:0], status[9:8], zero above
    output logic        m_axis_tuser,   // is_status
    output logic        m_axis_tlast
);

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_head_valid;
    b32dec_pkg::class_t q_push_entry;
    b32dec_pkg::class_t q_head_entry;

    b32dec_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_push_entry)
    );

    b32dec_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    b32dec_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (q_head_valid),
        .head_entry    (q_head_entry),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ sv/b32dec_front.sv @@
`timescale 1ns / 1ps

module b32dec_front (
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [b32dec_pkg::CharW-1:0] s_axis_tdata,
    input  logic                         s_axis_tlast,
    input  logic                         q_full,
    output logic                         q_push,
    output b32dec_pkg::class_t           q_entry
);

    b32dec_pkg::sym_t lookup;

    always_comb begin
        lookup             = b32dec_pkg::sym_lookup(s_axis_tdata);
        q_entry.sym_valid  = lookup.valid;
        q_entry.sym        = lookup.sym;
        q_entry.upper      = (s_axis_tdata >= 8'h41) && (s_axis_tdata <= 8'h5a);
        q_entry.lower      = (s_axis_tdata >= 8'h61) && (s_axis_tdata <= 8'h7a);
        q_entry.last       = s_axis_tlast;
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

endmodule

@@ sv/b32dec_queue.sv @@
`timescale 1ns / 1ps

module b32dec_queue #(
    parameter int unsigned Depth = b32dec_pkg::QueueDepth
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  b32dec_pkg::class_t push_entry,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output b32dec_pkg::class_t head_entry
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    b32dec_pkg::class_t slots_reg [Depth];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    logic do_push, do_pop;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ sv/b32dec_back.sv @@
`timescale 1ns / 1ps

module b32dec_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  b32dec_pkg::class_t            head_entry,
    output logic                          pop,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);

    localparam int unsigned SymW   = b32dec_pkg::SymW;
    localparam int unsigned ByteW  = b32dec_pkg::ByteW;
    localparam int unsigned CountW = b32dec_pkg::CountW;
    localparam int unsigned PendW  = b32dec_pkg::PendW;
    localparam int unsigned WideW  = PendW + SymW;

    logic [PendW-1:0]  acc_reg, acc_next;
    logic [CountW-1:0] cnt_reg, cnt_next;
    logic              upper_reg, upper_next;
    logic              lower_reg, lower_next;
    logic              invalid_reg, invalid_next;

    logic              out_valid_reg, out_valid_next;
    logic [ByteW-1:0]  out_byte_reg, out_byte_next;
    logic              out_is_status_reg, out_is_status_next;
    b32dec_pkg::status_t out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;
    logic              pend_valid_reg, pend_valid_next;
    b32dec_pkg::status_t pend_status_reg, pend_status_next;

    logic              out_free;
    logic [WideW-1:0]  wide;
    logic [CountW:0]   cnt_sum;
    logic [CountW:0]   cnt_left;
    logic              byte_ready;
    logic [ByteW-1:0]  new_byte;
    logic [CountW-1:0] upd_cnt;
    logic [PendW-1:0]  upd_acc;
    logic [WideW-1:0]  shifted;
    logic              upd_upper, upd_lower, upd_invalid;
    b32dec_pkg::status_t end_status;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign pop      = head_valid && out_free && !pend_valid_reg;

    always_comb begin
        wide       = {acc_reg, head_entry.sym};
        cnt_sum    = {1'b0, cnt_reg} + (CountW + 1)'(SymW);
        byte_ready = head_entry.sym_valid && (cnt_sum >= (CountW + 1)'(ByteW));
        cnt_left   = byte_ready ? cnt_sum - (CountW + 1)'(ByteW) : cnt_sum;
        shifted    = wide >> cnt_left;
        new_byte   = shifted[ByteW-1:0];
        upd_cnt    = head_entry.sym_valid ? cnt_left[CountW-1:0] : cnt_reg;
        upd_acc    = head_entry.sym_valid
                     ? wide[PendW-1:0] & ((PendW'(1) << upd_cnt) - PendW'(1))
                     : acc_reg;
        upd_upper   = upper_reg || head_entry.upper;
        upd_lower   = lower_reg || head_entry.lower;
        upd_invalid = invalid_reg || !head_entry.sym_valid;

        if (upd_upper && upd_lower) begin
            end_status = b32dec_pkg::ST_MIXED;
        end else if (upd_invalid) begin
            end_status = b32dec_pkg::ST_INVALID;
        end else if (upd_cnt != '0 && upd_acc != '0) begin
            end_status = b32dec_pkg::ST_NONZERO_PAD;
        end else begin
            end_status = b32dec_pkg::ST_OK;
        end
    end

    always_comb begin
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        upper_next   = upper_reg;
        lower_next   = lower_reg;
        invalid_next = invalid_reg;
        if (pop) begin
            if (head_entry.last) begin
                acc_next     = '0;
                cnt_next     = '0;
                upper_next   = 1'b0;
                lower_next   = 1'b0;
                invalid_next = 1'b0;
            end else begin
                acc_next     = upd_acc;
                cnt_next     = upd_cnt;
                upper_next   = upd_upper;
                lower_next   = upd_lower;
                invalid_next = upd_invalid;
            end
        end
    end

    always_comb begin
        out_valid_next     = out_valid_reg;
        out_byte_next      = out_byte_reg;
        out_is_status_next = out_is_status_reg;
        out_status_next    = out_status_reg;
        out_last_next      = out_last_reg;
        pend_valid_next    = pend_valid_reg;
        pend_status_next   = pend_status_reg;
        if (out_free) begin
            out_valid_next = 1'b0;
            if (pend_valid_reg) begin
                out_valid_next     = 1'b1;
                out_byte_next      = '0;
                out_is_status_next = 1'b1;
                out_status_next    = pend_status_reg;
                out_last_next      = 1'b1;
                pend_valid_next    = 1'b0;
            end else if (pop) begin
                if (byte_ready) begin
                    out_valid_next     = 1'b1;
                    out_byte_next      = new_byte;
                    out_is_status_next = 1'b0;
                    out_status_next    = b32dec_pkg::ST_OK;
                    out_last_next      = 1'b0;
                    pend_valid_next    = head_entry.last;
                    pend_status_next   = end_status;
                end else if (head_entry.last) begin
                    out_valid_next     = 1'b1;
                    out_byte_next      = '0;
                    out_is_status_next = 1'b1;
                    out_status_next    = end_status;
                    out_last_next      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg        <= '0;
            cnt_reg        <= '0;
            upper_reg      <= 1'b0;
            lower_reg      <= 1'b0;
            invalid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            upper_reg      <= upper_next;
            lower_reg      <= lower_next;
            invalid_reg    <= invalid_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg      <= out_byte_next;
        out_is_status_reg <= out_is_status_next;
        out_status_reg    <= out_status_next;
        out_last_reg      <= out_last_next;
        pend_status_reg   <= pend_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_status_reg, out_byte_reg};
    assign m_axis_tuser  = out_is_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ dv/tb_base32_symbol_to_byte_decoder.sv @@
`timescale 1ns / 1ps

module tb_base32_symbol_to_byte_decoder;

    typedef struct packed {
        logic [7:0]          data;
        logic                is_status;
        b32dec_pkg::status_t status;
        logic                eor;
    } word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // character[7:0]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // data_byte[7:0], status[9:8], zero above
    logic        m_axis_tuser;   // is_status
    logic        m_axis_tlast;

    string       b32_alphabet = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    word_t       decoded_words[$];
    logic [11:0] acc_bits;
    int          acc_count;
    logic        seen_upper;
    logic        seen_lower;
    logic        seen_bad;

    int          errors;
    int          tx_burst_left;
    logic        tx_offered;
    int          rx_hold;

    base32_symbol_to_byte_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    // Returns the symbol value in the low five bits and a valid flag above them.
    function automatic logic [5:0] symbol_value(input logic [7:0] ch);
        logic [7:0] lc;
        lc = (ch >= "A" && ch <= "Z") ? (ch | 8'h20) : ch;
        for (int i = 0; i < 32; i++) begin
            if (b32_alphabet[i] == lc) begin
                return {1'b1, 5'(i)};
            end
        end
        return 6'd0;
    endfunction

    function automatic logic [7:0] symbol_char(input int sym, input logic up);
        logic [7:0] c;
        c = b32_alphabet[sym];
        if (up && c >= "a" && c <= "z") begin
            c = c - 8'h20;
        end
        return c;
    endfunction

    task automatic decode_char(input logic [7:0] ch, input logic last);
        logic [5:0] sv;
        word_t      w;
        sv = symbol_value(ch);
        if (ch >= "A" && ch <= "Z") begin
            seen_upper = 1'b1;
        end
        if (ch >= "a" && ch <= "z") begin
            seen_lower = 1'b1;
        end
        if (!sv[5]) begin
            seen_bad = 1'b1;
        end else begin
            acc_bits = (acc_bits << 5) | 12'(sv[4:0]);
            acc_count += 5;
            if (acc_count >= 8) begin
                acc_count -= 8;
                w = '{data: 8'(acc_bits >> acc_count), is_status: 1'b0,
                      status: b32dec_pkg::ST_OK, eor: 1'b0};
                decoded_words = {decoded_words, w};
            end
            acc_bits = acc_bits & ((12'd1 << acc_count) - 12'd1);
        end
        if (last) begin
            w = '{data: 8'h00, is_status: 1'b1, status: b32dec_pkg::ST_OK, eor: 1'b1};
            if (seen_upper && seen_lower) begin
                w.status = b32dec_pkg::ST_MIXED;
            end else if (seen_bad) begin
                w.status = b32dec_pkg::ST_INVALID;
            end else if (acc_count != 0 && acc_bits != 12'd0) begin
                w.status = b32dec_pkg::ST_NONZERO_PAD;
            end
            decoded_words = {decoded_words, w};
            acc_bits   = '0;
            acc_count  = 0;
            seen_upper = 1'b0;
            seen_lower = 1'b0;
            seen_bad   = 1'b0;
        end
    endtask

    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0 && tx_offered) begin
                s_axis_tvalid <= 1'b0;
                tx_offered = 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
        tx_burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        tx_offered = 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        decode_char(ch, last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    task automatic wait_drain();
        if (tx_offered) begin
            s_axis_tvalid <= 1'b0;
            tx_offered = 1'b0;
        end
        while (decoded_words.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random_string(output int sent);
        int         len;
        int         kind;
        int         sym;
        int         p;
        logic       up;
        logic [7:0] ch;
        string      bad_chars;
        bad_chars = "1bioBIO!";
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        kind = $urandom_range(0, 9);
        up   = 1'($urandom_range(0, 1));
        for (int i = 0; i < len; i++) begin
            sym = $urandom_range(0, 31);
            if (i == len - 1 && $urandom_range(0, 1)) begin
                p = (5 * len) % 8;
                if (p > 5) begin
                    p = 5;
                end
                sym = sym & ~((1 << p) - 1);
            end
            ch = symbol_char(sym, up);
            if (kind == 8) begin
                ch = 8'($urandom_range(0, 255));
            end else if (kind == 9 && $urandom_range(0, len - 1) == 0) begin
                case ($urandom_range(0, 2))
                    0: begin
                        ch = symbol_char(sym, !up);
                    end
                    1: begin
                        ch = bad_chars[$urandom_range(0, 7)];
                    end
                    default: begin
                        ch = 8'($urandom_range(128, 255));
                    end
                endcase
            end
            send_char(ch, i == len - 1);
        end
        sent = len;
    endtask

    task automatic test_directed();
        send_text("ll");
        send_text("lq");
        send_text("LQ");
        send_text("Lq");
        send_text("b");
        send_char(8'hff, 1'b1);
        send_text("Ab");
        send_text("q");
        send_text("l");
        send_char(8'h00, 1'b1);
        send_char(8'h80, 1'b1);
        send_text("lb");
        send_text("Bi");
        wait_drain();
    endtask

    task automatic test_backpressure();
        int n;
        int total;
        total = 0;
        rx_hold = 300;
        while (total < 80) begin
            send_random_string(n);
            total += n;
        end
        wait_drain();
    endtask

    task automatic test_drain_pause();
        int n;
        for (int i = 0; i < 4; i++) begin
            send_random_string(n);
            wait_drain();
        end
    endtask

    task automatic test_random();
        int n;
        int total;
        total = 0;
        while (total < 1600) begin
            send_random_string(n);
            total += n;
            if ($urandom_range(0, 29) == 0) begin
                wait_drain();
            end
        end
        wait_drain();
    endtask

    initial begin : receiver
        int mode;
        int mode_left;
        m_axis_tready <= 1'b0;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(1, 64);
            end
            mode_left--;
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : check_words
        word_t w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (decoded_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, got tdata %04h user %b last %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end else begin
                w = decoded_words.pop_front();
                if (m_axis_tdata[7:0] !== w.data) begin
                    $display("%0t: data_byte expected %02h, actual %02h",
                             $time, w.data, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[9:8] !== w.status) begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, w.status, m_axis_tdata[9:8]);
                    errors++;
                end
                if (m_axis_tdata[15:10] !== 6'd0) begin
                    $display("%0t: tdata[15:10] expected 00, actual %02h",
                             $time, m_axis_tdata[15:10]);
                    errors++;
                end
                if (m_axis_tuser !== w.is_status) begin
                    $display("%0t: is_status expected %b, actual %b",
                             $time, w.is_status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== w.eor) begin
                    $display("%0t: end_of_run expected %b, actual %b",
                             $time, w.eor, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors        = 0;
        tx_burst_left = 0;
        tx_offered    = 1'b0;
        rx_hold       = 0;
        acc_bits      = '0;
        acc_count     = 0;
        seen_upper    = 1'b0;
        seen_lower    = 1'b0;
        seen_bad      = 1'b0;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ base32_symbol_to_byte_decoder.f @@
sv/b32dec_pkg.sv
sv/b32dec_front.sv
sv/b32dec_queue.sv
sv/b32dec_back.sv
sv/base32_symbol_to_byte_decoder.sv
dv/tb_base32_symbol_to_byte_decoder.sv
